[rtl/pcg_pkg.sv]
// constants and the helper function shared by the pcg32 generator files
package pcg_pkg;

    localparam int STATE_W   = 64;
    localparam int WORD_W    = 32;
    localparam int SEQ_W     = 63;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_CNT_W = $clog2(WORD_W);
    localparam int ROT_W     = 5;

    localparam logic [STATE_W-1:0] PCG_MULT       = 64'h5851_F42D_4C95_7F2D;
    localparam logic [STATE_W-1:0] PCG_STATE_INIT = 64'h853C_49E6_748F_EA9B;
    localparam logic [STATE_W-1:0] PCG_INC_INIT   = 64'hDA3E_39CB_94B9_5BDB;

    localparam int XS_SHIFT_A = 18;
    localparam int XS_SHIFT_B = 27;
    localparam int ROT_SHIFT  = 59;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_STATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_SEQUENCE = 2'd1;

    // input commands
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    // xsh-rr output permutation of a 64-bit state
    function automatic logic [WORD_W-1:0] pcg_permute(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] mixed;
        logic [WORD_W-1:0]  xs;
        logic [ROT_W-1:0]   rot;
        logic [2*WORD_W-1:0] twice;
        mixed = (s ^ (s >> XS_SHIFT_A)) >> XS_SHIFT_B;
        xs    = mixed[WORD_W-1:0];
        rot   = s[ROT_SHIFT +: ROT_W];
        twice = {xs, xs} >> rot;
        return twice[WORD_W-1:0];
    endfunction

endpackage

[rtl/pcg_if.sv]
// handshake channel interfaces of the pcg32 generator

// command channel
interface pcg_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] range_limit;

    modport source (output valid, output command, output range_limit, input ready);
    modport sink   (input valid, input command, input range_limit, output ready);
endinterface

// result channel
interface pcg_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_value;
    logic [31:0] bounded_value;

    modport source (output valid, output raw_value, output bounded_value, input ready);
    modport sink   (input valid, input raw_value, input bounded_value, output ready);
endinterface

// configuration write channel
interface pcg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pcg32_random_generator_unit.sv]
// pcg32 xsh-rr generator: draw gives raw and bounded output, reseed reloads the lcg
// draw: result registered after the 32-step divider, once the result register is free
// reseed: runs the 4-step 64-bit multiply-add; no result
// one command at a time, the next taken only after the last one finishes; a new
// command is taken while the result register still waits
// reset: lcg state and increment take defaults, seeds clear; ready in the first cycle
module pcg32_random_generator_unit (
    input  logic clk,
    input  logic rst_n,
    pcg_cmd_if.sink   cmd,
    pcg_res_if.source res,
    pcg_cfg_if.sink   cfg
);
    import pcg_pkg::*;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t               state_reg;
    logic [STATE_W-1:0]   lcg_reg;
    logic [STATE_W-1:0]   inc_reg;
    logic [STATE_W-1:0]   seed_state_reg;
    logic [SEQ_W-1:0]     seed_sequence_reg;
    logic                 draw_reg;
    logic                 lim_zero_reg;
    logic [WORD_W-1:0]    raw_reg;
    logic                 res_valid_reg;
    logic [WORD_W-1:0]    res_raw_reg;
    logic [WORD_W-1:0]    res_bounded_reg;

    logic                 cmd_fire;
    logic                 is_reseed;
    logic [STATE_W-1:0]   reseed_inc;
    logic [WORD_W-1:0]    perm;
    logic                 units_idle;
    logic                 slot_free;
    logic                 res_load;
    logic [STATE_W-1:0]   mul_operand;
    logic [STATE_W-1:0]   mul_addend;
    logic                 mul_busy;
    logic [STATE_W-1:0]   mul_result;
    logic                 div_busy;
    logic [WORD_W-1:0]    div_rem;

    // handshake and operand selection
    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cmd_fire    = cmd.valid && cmd.ready;
    assign is_reseed   = (cmd.command == CMD_RESEED);
    assign reseed_inc  = {seed_sequence_reg, 1'b1};
    assign perm        = pcg_permute(lcg_reg);
    assign mul_operand = is_reseed ? (reseed_inc + seed_state_reg) : lcg_reg;
    assign mul_addend  = is_reseed ? reseed_inc : inc_reg;
    assign units_idle  = !mul_busy && !div_busy;
    assign slot_free   = !res_valid_reg || res.ready;
    assign res_load    = (state_reg == ST_RUN) && units_idle && draw_reg && slot_free;

    // shared multiply-add for the lcg advance
    pcg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd_fire),
        .operand (mul_operand),
        .addend  (mul_addend),
        .busy    (mul_busy),
        .result  (mul_result)
    );

    // bounded output remainder
    pcg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd_fire && !is_reseed),
        .dividend  (perm),
        .divisor   (cmd.range_limit),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_state_reg    <= '0;
            seed_sequence_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_SEED_STATE:    seed_state_reg    <= cfg.data;
                CFG_SEED_SEQUENCE: seed_sequence_reg <= cfg.data[SEQ_W-1:0];
                default:           ;
            endcase
        end
    end

    // sequencer, generator state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            lcg_reg         <= PCG_STATE_INIT;
            inc_reg         <= PCG_INC_INIT;
            draw_reg        <= 1'b0;
            lim_zero_reg    <= 1'b0;
            raw_reg         <= '0;
            res_valid_reg   <= 1'b0;
            res_raw_reg     <= '0;
            res_bounded_reg <= '0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire)
                    begin
                        draw_reg     <= !is_reseed;
                        lim_zero_reg <= (cmd.range_limit == '0);
                        raw_reg      <= perm;
                        if (is_reseed)
                        begin
                            inc_reg <= reseed_inc;
                        end
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (units_idle && (!draw_reg || slot_free))
                    begin
                        lcg_reg <= mul_result;
                        if (draw_reg)
                        begin
                            res_raw_reg     <= raw_reg;
                            res_bounded_reg <= lim_zero_reg ? '0 : div_rem;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.raw_value     = res_raw_reg;
    assign res.bounded_value = res_bounded_reg;

    // units are never running while a command can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mul_busy && !div_busy)
        else $error("arithmetic unit busy while idle");

    // a result appears only for a draw command
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(draw_reg))
        else $error("result produced by reseed");

    // the lcg increment stays odd
    assert property (@(posedge clk) disable iff (!rst_n) inc_reg[0])
        else $error("lcg increment is even");

    // a pending result stays valid until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |=> res_valid_reg)
        else $error("pending result dropped");

endmodule

[rtl/pcg_mul.sv]
// iterative 64-bit multiply-add by the lcg multiplier over one 32x32 multiplier
module pcg_mul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [pcg_pkg::STATE_W-1:0] operand,
    input  logic [pcg_pkg::STATE_W-1:0] addend,
    output logic                   busy,
    output logic [pcg_pkg::STATE_W-1:0] result
);
    import pcg_pkg::*;

    logic                 busy_reg;
    logic [1:0]           step_reg;
    logic [STATE_W-1:0]   operand_reg;
    logic [STATE_W-1:0]   acc_reg;
    logic [STATE_W-1:0]   prod_reg;
    logic [WORD_W-1:0]    mul_a;
    logic [WORD_W-1:0]    mul_b;
    logic [STATE_W-1:0]   mul_p;

    // operand selection for the shared multiplier
    always_comb
    begin
        case (step_reg)
            2'd0:    begin mul_a = operand_reg[WORD_W-1:0];        mul_b = PCG_MULT[WORD_W-1:0]; end
            2'd1:    begin mul_a = operand_reg[WORD_W-1:0];        mul_b = PCG_MULT[STATE_W-1:WORD_W]; end
            2'd2:    begin mul_a = operand_reg[STATE_W-1:WORD_W];  mul_b = PCG_MULT[WORD_W-1:0]; end
            default: begin mul_a = '0;                             mul_b = '0; end
        endcase
    end

    assign mul_p = STATE_W'(mul_a) * STATE_W'(mul_b);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath: low product plus addend, then the two cross products into the top half
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            operand_reg <= operand;
            acc_reg     <= addend;
        end
        else if (busy_reg)
        begin
            prod_reg <= mul_p;
            case (step_reg)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= acc_reg + prod_reg;
                default: acc_reg <= acc_reg + {prod_reg[WORD_W-1:0], {WORD_W{1'b0}}};
            endcase
        end
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

    // step counter parks at zero while idle
    assert property (@(posedge clk) disable iff (!rst_n) !busy_reg |-> step_reg == 2'd0)
        else $error("multiplier step counter not parked");

endmodule

[rtl/pcg_div.sv]
// restoring divider, one quotient bit per cycle, remainder only
module pcg_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pcg_pkg::WORD_W-1:0] dividend,
    input  logic [pcg_pkg::WORD_W-1:0] divisor,
    output logic                       busy,
    output logic [pcg_pkg::WORD_W-1:0] remainder
);
    import pcg_pkg::*;

    logic                  busy_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0]     quo_reg;
    logic [WORD_W-1:0]     rem_reg;
    logic [WORD_W-1:0]     divisor_reg;
    logic [WORD_W:0]       shifted;
    logic [WORD_W:0]       trial;

    // one compare and subtract step
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, divisor_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '1;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            if (!trial[WORD_W])
            begin
                rem_reg <= trial[WORD_W-1:0];
            end
            else
            begin
                rem_reg <= shifted[WORD_W-1:0];
            end
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

    // a finished remainder is below a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) && divisor_reg != '0 |-> rem_reg < divisor_reg)
        else $error("remainder not below divisor");

endmodule

[sim/tb_top.sv]
// self-checking testbench of the pcg32 xsh-rr generator: draws, reseeds and seed register writes
`timescale 1ns / 100ps

module tb_top;
    import pcg_pkg::*;

    // register indexes outside the map, writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_3 = 2'd3;
    localparam int SETTLE_CYCLES  = 60;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 118;

    typedef struct packed {
        logic              command;
        logic [WORD_W-1:0] range_limit;
    } gen_cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] raw_value;
        logic [WORD_W-1:0] bounded_value;
    } draw_result_t;

    logic clk;
    logic rst_n;

    pcg_cmd_if cmd_ch ();
    pcg_res_if res_ch ();
    pcg_cfg_if cfg_ch ();

    pcg32_random_generator_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // commands waiting to be driven and draws waiting for their result
    gen_cmd_t     pending_cmds[$];
    draw_result_t expected_draws[$];

    // shadow copy of the generator state and seed registers
    logic [STATE_W-1:0] shadow_state = PCG_STATE_INIT;
    logic [STATE_W-1:0] shadow_inc   = PCG_INC_INIT;
    logic [STATE_W-1:0] shadow_seed_state;
    logic [SEQ_W-1:0]   shadow_seed_seq;

    int  mismatches    = 0;
    int  stray_results = 0;
    int  cmd_gap;
    int  res_stall;
    bit  quiet;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // xsh-rr output word of a 64-bit lcg state
    function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] folded;
        logic [WORD_W-1:0]  word;
        int unsigned        amt;
        folded = ((s >> XS_SHIFT_A) ^ s) >> XS_SHIFT_B;
        word   = folded[WORD_W-1:0];
        amt    = 32'(s[STATE_W-1:ROT_SHIFT]);
        if (amt == 0)
            return word;
        return (word >> amt) | (word << (WORD_W - amt));
    endfunction

    function automatic logic [STATE_W-1:0] lcg_next(input logic [STATE_W-1:0] s,
                                                    input logic [STATE_W-1:0] inc);
        return s * PCG_MULT + inc;
    endfunction

    // apply one accepted command to the shadow generator
    task automatic predict_command(input logic command, input logic [WORD_W-1:0] limit);
        draw_result_t r;
        if (command == CMD_RESEED)
        begin
            shadow_inc   = {shadow_seed_seq, 1'b1};
            shadow_state = lcg_next('0, shadow_inc);
            shadow_state = shadow_state + shadow_seed_state;
            shadow_state = lcg_next(shadow_state, shadow_inc);
        end
        else
        begin
            r.raw_value     = xsh_rr(shadow_state);
            r.bounded_value = (limit == '0) ? '0 : r.raw_value % limit;
            shadow_state    = lcg_next(shadow_state, shadow_inc);
            expected_draws.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s at %0t: expected %08h, got %08h", field, $realtime,
                     want, got);
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        gen_cmd_t nxt;
        logic     nxt_valid;
        if (!rst_n)
        begin
            cmd_ch.valid       <= 1'b0;
            cmd_ch.command     <= CMD_DRAW;
            cmd_ch.range_limit <= '0;
            cmd_gap = 0;
        end
        else
        begin
            nxt_valid = cmd_ch.valid;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                predict_command(cmd_ch.command, cmd_ch.range_limit);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (cmd_gap > 0)
                    cmd_gap--;
                else if (pending_cmds.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 7) == 0)
                        cmd_gap = $urandom_range(1, 7) - 1;
                    else
                    begin
                        nxt = pending_cmds.pop_front();
                        cmd_ch.command     <= nxt.command;
                        cmd_ch.range_limit <= nxt.range_limit;
                        nxt_valid = 1'b1;
                    end
                end
            end
            cmd_ch.valid <= nxt_valid;
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : res_monitor
        draw_result_t want;
        logic         nxt_ready;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            res_stall = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_draws.size() == 0)
                begin
                    stray_results++;
                    $display("result with no draw pending at %0t: raw %08h bounded %08h",
                             $realtime, res_ch.raw_value, res_ch.bounded_value);
                end
                else
                begin
                    want = expected_draws.pop_front();
                    if (res_ch.raw_value !== want.raw_value)
                        report_mismatch("raw_value", want.raw_value, res_ch.raw_value);
                    if (res_ch.bounded_value !== want.bounded_value)
                        report_mismatch("bounded_value", want.bounded_value,
                                        res_ch.bounded_value);
                end
            end
            if (res_stall > 0)
            begin
                res_stall--;
                nxt_ready = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                res_stall = $urandom_range(1, 7) - 1;
                nxt_ready = 1'b0;
            end
            else
                nxt_ready = 1'b1;
            res_ch.ready <= nxt_ready;
        end
    end

    task automatic push_cmd(input logic command, input logic [WORD_W-1:0] limit);
        gen_cmd_t c;
        c.command     = command;
        c.range_limit = limit;
        pending_cmds.push_back(c);
    endtask

    // one seed register write transaction
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STATE_W-1:0] data);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_SEED_STATE:    shadow_seed_state = data;
            CFG_SEED_SEQUENCE: shadow_seed_seq   = data[SEQ_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // wait until every command is taken and every draw has returned
    task automatic settle();
        @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_draws.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3: return $urandom_range(1, 16);
            4:       return ($urandom_range(0, 1) == 0) ? '1 : {1'b1, 31'(0)};
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [STATE_W-1:0] pick_seed();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // random seed settings for one phase, in random order, sometimes with an unmapped write
    task automatic random_config();
        if ($urandom_range(0, 1) == 0)
        begin
            write_reg(CFG_SEED_STATE, pick_seed());
            write_reg(CFG_SEED_SEQUENCE, pick_seed());
        end
        else
        begin
            write_reg(CFG_SEED_SEQUENCE, pick_seed());
            write_reg(CFG_SEED_STATE, pick_seed());
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? CFG_UNMAPPED_2 : CFG_UNMAPPED_3,
                      {$urandom(), $urandom()});
    endtask

    // stimulus
    initial
    begin
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_SEED_STATE;
        cfg_ch.data        = '0;
        shadow_seed_state  = '0;
        shadow_seed_seq    = '0;
        quiet              = 1'b0;
        rst_n              = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default state after reset: range extremes, zero range, reseed with cleared seeds
        push_cmd(CMD_DRAW, 32'h0000_0000);
        push_cmd(CMD_DRAW, 32'h0000_0001);
        push_cmd(CMD_DRAW, 32'h0000_0002);
        push_cmd(CMD_DRAW, 32'hFFFF_FFFF);
        push_cmd(CMD_DRAW, 32'h8000_0000);
        push_cmd(CMD_DRAW, 32'h7FFF_FFFF);
        push_cmd(CMD_DRAW, 32'h0000_0003);
        push_cmd(CMD_DRAW, 32'h0000_0010);
        push_cmd(CMD_RESEED, 32'h0000_0000);
        push_cmd(CMD_DRAW, 32'h0000_0000);
        push_cmd(CMD_DRAW, 32'hFFFF_FFFF);
        push_cmd(CMD_DRAW, 32'h0000_0005);
        settle();

        // all-ones seeds, sequence bit above the register width, unmapped indexes
        write_reg(CFG_SEED_STATE, '1);
        write_reg(CFG_SEED_SEQUENCE, '1);
        write_reg(CFG_UNMAPPED_2, {$urandom(), $urandom()});
        write_reg(CFG_UNMAPPED_3, {$urandom(), $urandom()});
        push_cmd(CMD_RESEED, 32'hFFFF_FFFF);
        push_cmd(CMD_DRAW, 32'h0000_0000);
        push_cmd(CMD_DRAW, 32'h0000_0001);
        push_cmd(CMD_DRAW, 32'hFFFF_FFFF);
        push_cmd(CMD_DRAW, 32'hAAAA_AAAA);
        push_cmd(CMD_DRAW, 32'h5555_5555);
        push_cmd(CMD_RESEED, 32'h0000_0000);
        push_cmd(CMD_RESEED, 32'h1234_5678);
        push_cmd(CMD_DRAW, 32'h0000_0007);
        settle();

        // zero seeds
        write_reg(CFG_SEED_STATE, '0);
        write_reg(CFG_SEED_SEQUENCE, '0);
        push_cmd(CMD_RESEED, 32'h0000_0000);
        push_cmd(CMD_DRAW, 32'h0000_3039);
        push_cmd(CMD_DRAW, 32'h0000_0000);
        settle();

        // random phases, each with its own seed setting; the last one without idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_config();
            if (p == RANDOM_PHASES - 1)
                quiet = 1'b1;
            if ($urandom_range(0, 3) != 0)
                push_cmd(CMD_RESEED, $urandom());
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    push_cmd(CMD_RESEED, $urandom());
                else
                    push_cmd(CMD_DRAW, pick_limit());
            end
            settle();
        end

        if (mismatches == 0 && stray_results == 0 && expected_draws.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/pcg_pkg.sv
rtl/pcg_if.sv
rtl/pcg_mul.sv
rtl/pcg_div.sv
rtl/pcg32_random_generator_unit.sv
sim/tb_top.sv
